// File: rtl/core/weighted_choice_sampler_assert.svh
// Assertion macros for the weighted choice sampler.
// Each macro takes a label, an antecedent and a consequent, clocked on clk
// and disabled during rst.
`ifndef WEIGHTED_CHOICE_SAMPLER_ASSERT_SVH
`define WEIGHTED_CHOICE_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define WCS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wcs assertion failed");
// Next-cycle implication.
`define WCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wcs assertion failed");
`else
`define WCS_ASSERT_IMPL(label, ante, cons)
`define WCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/wcs_pkg.sv
package wcs_pkg;

  // Parameter defaults
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int WEIGHT_BITS_DEF = 32;
  localparam int DRAW_BITS_DEF   = 32;

  // Fixed field widths
  localparam int SITE_BITS   = 31;
  localparam int ALLELE_BITS = 8;
  localparam int FIELD_BITS  = 32;
  localparam int TOTAL_BITS  = 48;
  localparam int HALF_BITS   = 24;
  localparam int IDX_BITS    = 17;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [ALLELE_BITS-1:0] EMPTY_CODE = 8'h4E;

  // Input kind codes
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_CHOOSE = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_CHOOSE,
    OP_EMPTY
  } op_t;

  // Command word passed from front to back
  typedef struct packed {
    op_t                    op;
    logic [IDX_BITS-1:0]    idx;
    logic [SITE_BITS-1:0]   site;
    logic [ALLELE_BITS-1:0] ref_allele;
    logic [ALLELE_BITS-1:0] alt_allele;
    logic [FIELD_BITS-1:0]  weight;
    logic [FIELD_BITS-1:0]  draw;
  } cmd_t;

  // Stored table entry
  typedef struct packed {
    logic [SITE_BITS-1:0]   site;
    logic [ALLELE_BITS-1:0] ref_allele;
    logic [ALLELE_BITS-1:0] alt_allele;
    logic [FIELD_BITS-1:0]  weight;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_THRESH,
    BK_SEARCH,
    BK_DONE
  } back_state_t;

endpackage

// File: rtl/core/wcs_if.sv
interface wcs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [wcs_pkg::SITE_BITS-1:0]       site;
  logic [wcs_pkg::FIELD_BITS-1:0]      weight;
  logic [wcs_pkg::ALLELE_BITS-1:0]     ref_allele;
  logic [wcs_pkg::ALLELE_BITS-1:0]     alt_allele;
  logic [wcs_pkg::FIELD_BITS-1:0]      random_draw;

  modport source (
    output valid, kind, site, weight, ref_allele, alt_allele, random_draw,
    input  ready
  );
  modport sink (
    input  valid, kind, site, weight, ref_allele, alt_allele, random_draw,
    output ready
  );
endinterface

interface wcs_out_if;
  logic                                valid;
  logic                                ready;
  logic                                empty_res;
  logic signed [wcs_pkg::FIELD_BITS-1:0] chosen_site;
  logic [wcs_pkg::ALLELE_BITS-1:0]     chosen_ref;
  logic [wcs_pkg::ALLELE_BITS-1:0]     chosen_alt;
  logic [wcs_pkg::FIELD_BITS-1:0]      chosen_weight;
  logic [wcs_pkg::TOTAL_BITS-1:0]      total_weight;

  modport source (
    output valid, empty_res, chosen_site, chosen_ref, chosen_alt, chosen_weight,
           total_weight,
    input  ready
  );
  modport sink (
    input  valid, empty_res, chosen_site, chosen_ref, chosen_alt, chosen_weight,
           total_weight,
    output ready
  );
endinterface

// File: rtl/core/wcs_front.sv
module wcs_front #(
  parameter int MAX_ENTRIES = wcs_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wcs_pkg::WEIGHT_BITS_DEF,
  parameter int DRAW_BITS   = wcs_pkg::DRAW_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  wcs_in_if.sink         items,
  input  logic           q_full,
  output logic           push,
  output wcs_pkg::cmd_t  cmd
);

  localparam int CW        = $clog2(MAX_ENTRIES + 1);
  localparam int FieldBits = wcs_pkg::FIELD_BITS;
  localparam int IdxBits   = wcs_pkg::IDX_BITS;
  localparam int WB        = (WEIGHT_BITS < FieldBits) ? WEIGHT_BITS : FieldBits;
  localparam int DB        = (DRAW_BITS < FieldBits) ? DRAW_BITS : FieldBits;
  localparam logic [FieldBits-1:0] WMask = FieldBits'((64'd1 << WB) - 64'd1);
  localparam logic [FieldBits-1:0] DMask = FieldBits'((64'd1 << DB) - 64'd1);

  logic [CW-1:0] cnt;
  logic          accept;
  logic          is_add;
  logic          tbl_full;

  // Take a word whenever the queue has room
  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;
  assign is_add      = (items.kind == wcs_pkg::KIND_ADD);
  assign tbl_full    = (cnt == CW'(MAX_ENTRIES));

  // Drop adds once the table is full
  assign push = accept && !(is_add && tbl_full);

  // Classify and build the command word
  always_comb begin
    if (is_add) begin
      cmd.op = wcs_pkg::OP_ADD;
    end else if (cnt == '0) begin
      cmd.op = wcs_pkg::OP_EMPTY;
    end else begin
      cmd.op = wcs_pkg::OP_CHOOSE;
    end
    cmd.idx        = IdxBits'(cnt);
    cmd.site       = items.site;
    cmd.ref_allele = items.ref_allele;
    cmd.alt_allele = items.alt_allele;
    cmd.weight     = items.weight & WMask;
    cmd.draw       = items.random_draw & DMask;
  end

  // Track the number of entries handed to the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push && is_add) begin
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: rtl/core/wcs_fifo.sv
module wcs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wcs_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output wcs_pkg::cmd_t  pop_data,
  output logic           not_empty
);

  localparam int Depth = wcs_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  wcs_pkg::cmd_t   slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign full      = (fill == CntW'(Depth));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/wcs_back.sv
`include "weighted_choice_sampler_assert.svh"

module wcs_back #(
  parameter int MAX_ENTRIES = wcs_pkg::MAX_ENTRIES_DEF,
  parameter int DRAW_BITS   = wcs_pkg::DRAW_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  wcs_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  wcs_out_if.source      results
);

  localparam int IW        = $clog2(MAX_ENTRIES);
  localparam int CW        = $clog2(MAX_ENTRIES + 1);
  localparam int FieldBits = wcs_pkg::FIELD_BITS;
  localparam int TB        = wcs_pkg::TOTAL_BITS;
  localparam int HB        = wcs_pkg::HALF_BITS;
  localparam int PB        = FieldBits + HB;
  localparam int SB        = PB + HB;

  wcs_pkg::back_state_t state, state_next;

  // Tables
  logic [TB-1:0]   cum_mem [MAX_ENTRIES];
  wcs_pkg::entry_t ent_mem [MAX_ENTRIES];
  logic [TB-1:0]   cum_rd;
  wcs_pkg::entry_t ent_rd;

  // Datapath registers
  logic [TB-1:0]        running_total;
  logic [FieldBits-1:0] u_q;
  logic [CW-1:0]        cnt_q;
  logic                 is_empty_q;
  logic [PB-1:0]        plo;
  logic [PB-1:0]        phi;
  logic [TB-1:0]        thr;
  logic [CW-1:0]        lo_q;
  logic [CW-1:0]        hi_q;
  logic [CW-1:0]        mid_q;

  // Output register
  logic                 out_valid;
  logic                 res_empty;
  logic [FieldBits-1:0] res_site;
  logic [7:0]           res_ref;
  logic [7:0]           res_alt;
  logic [FieldBits-1:0] res_weight;
  logic [TB-1:0]        res_total;

  // Combinational controls
  logic          is_add;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [TB:0]   total_sum;
  logic [TB-1:0] total_n;
  logic [HB-1:0] mul_b;
  logic [PB-1:0] prod;
  logic [SB-1:0] scaled;
  logic          go_right;
  logic [CW-1:0] lo_n;
  logic [CW-1:0] hi_n;
  logic [CW-1:0] mid_n;
  logic [CW-1:0] pick;
  logic          cum_re;
  logic [CW-1:0] cum_raddr;
  logic          ent_re;
  logic          load_out;

  // Saturating running total
  assign total_sum = {1'b0, running_total} + (TB + 1)'(cmd.weight);
  assign total_n   = total_sum[TB] ? {TB{1'b1}} : total_sum[TB-1:0];
  assign is_add    = (cmd.op == wcs_pkg::OP_ADD);
  assign wr_addr   = cmd.idx[IW-1:0];

  // Shared 32x24 multiplier: low half of the total, then the high half
  assign mul_b  = (state == wcs_pkg::BK_MUL_LO) ? running_total[HB-1:0]
                                                : running_total[TB-1:HB];
  assign prod   = PB'(u_q) * PB'(mul_b);
  assign scaled = {phi, {HB{1'b0}}} + SB'(plo);

  // One search step per cycle
  assign go_right = (cum_rd < thr);
  assign lo_n     = go_right ? mid_q + 1'b1 : lo_q;
  assign hi_n     = go_right ? hi_q : mid_q;
  assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);
  assign pick     = (lo_n >= cnt_q) ? cnt_q - 1'b1 : lo_n;

  // Next state and controls
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    cum_re     = 1'b0;
    cum_raddr  = mid_n;
    ent_re     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      wcs_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid) begin
          unique case (cmd.op)
            wcs_pkg::OP_ADD:    wr_en = 1'b1;
            wcs_pkg::OP_CHOOSE: state_next = wcs_pkg::BK_MUL_LO;
            wcs_pkg::OP_EMPTY:  state_next = wcs_pkg::BK_DONE;
            default:            state_next = wcs_pkg::BK_IDLE;
          endcase
        end
      end
      wcs_pkg::BK_MUL_LO: state_next = wcs_pkg::BK_MUL_HI;
      wcs_pkg::BK_MUL_HI: state_next = wcs_pkg::BK_THRESH;
      wcs_pkg::BK_THRESH: begin
        // Issue the first probe at the middle of the table
        cum_re     = 1'b1;
        cum_raddr  = cnt_q >> 1;
        state_next = wcs_pkg::BK_SEARCH;
      end
      wcs_pkg::BK_SEARCH: begin
        if (lo_n < hi_n) begin
          cum_re = 1'b1;
        end else begin
          ent_re     = 1'b1;
          state_next = wcs_pkg::BK_DONE;
        end
      end
      wcs_pkg::BK_DONE: begin
        load_out = !out_valid || results.ready;
        if (load_out) begin
          state_next = wcs_pkg::BK_IDLE;
        end
      end
      default: state_next = wcs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcs_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cum_mem[wr_addr] <= total_n;
      ent_mem[wr_addr] <= '{site: cmd.site, ref_allele: cmd.ref_allele,
                            alt_allele: cmd.alt_allele, weight: cmd.weight};
    end
    if (cum_re) begin
      cum_rd <= cum_mem[cum_raddr[IW-1:0]];
    end
    if (ent_re) begin
      ent_rd <= ent_mem[pick[IW-1:0]];
    end
  end

  // Running total
  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (wr_en) begin
      running_total <= total_n;
    end
  end

  // Choose datapath
  always_ff @(posedge clk) begin
    if (cmd_pop && !is_add) begin
      u_q        <= cmd.draw;
      cnt_q      <= cmd.idx[CW-1:0];
      is_empty_q <= (cmd.op == wcs_pkg::OP_EMPTY);
    end
    if (state == wcs_pkg::BK_MUL_LO) begin
      plo <= prod;
    end
    if (state == wcs_pkg::BK_MUL_HI) begin
      phi <= prod;
    end
    if (state == wcs_pkg::BK_THRESH) begin
      // Drop the draw's fraction bits from the scaled product
      thr   <= TB'(scaled >> DRAW_BITS);
      lo_q  <= '0;
      hi_q  <= cnt_q;
      mid_q <= cnt_q >> 1;
    end
    if (state == wcs_pkg::BK_SEARCH) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_empty <= is_empty_q;
      res_total <= running_total;
      if (is_empty_q) begin
        res_site   <= {FieldBits{1'b1}};
        res_ref    <= wcs_pkg::EMPTY_CODE;
        res_alt    <= wcs_pkg::EMPTY_CODE;
        res_weight <= '0;
      end else begin
        res_site   <= {1'b0, ent_rd.site};
        res_ref    <= ent_rd.ref_allele;
        res_alt    <= ent_rd.alt_allele;
        res_weight <= ent_rd.weight;
      end
    end
  end

  assign results.valid         = out_valid;
  assign results.empty_res     = res_empty;
  assign results.chosen_site   = res_site;
  assign results.chosen_ref    = res_ref;
  assign results.chosen_alt    = res_alt;
  assign results.chosen_weight = res_weight;
  assign results.total_weight  = res_total;

  // Search window stays open and inside the table
  `WCS_ASSERT_IMPL(a_search_open, state == wcs_pkg::BK_SEARCH, lo_q < hi_q)
  `WCS_ASSERT_IMPL(a_search_bound, state == wcs_pkg::BK_SEARCH, hi_q <= cnt_q)
  // Total never falls on an add
  `WCS_ASSERT_NEXT(a_total_grows, wr_en, running_total >= $past(running_total))
  // A finished choose always lands in the output register
  `WCS_ASSERT_NEXT(a_result_loaded, load_out, out_valid && (state == wcs_pkg::BK_IDLE))

endmodule

// File: rtl/core/weighted_choice_sampler.sv
// Choose path: a choose word passes through the low and high multiply states, the threshold
// state and the binary-search probes, at most ceil(log2(n + 1)) for n entries, to the result
// register; on an empty table the choose goes straight to the result register.
// Throughput: the back end retires one add word per cycle while no choose is in flight and holds
// a choose until its result is loaded; the front accepts one word per cycle while the four-deep command queue has room.
// Reset (rst, synchronous) empties the table, clears the total, the queue and the result.
module weighted_choice_sampler #(
  parameter int MAX_ENTRIES = wcs_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wcs_pkg::WEIGHT_BITS_DEF,
  parameter int DRAW_BITS   = wcs_pkg::DRAW_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  wcs_in_if.sink     items,
  wcs_out_if.source  results
);

  wcs_pkg::cmd_t push_cmd;
  wcs_pkg::cmd_t pop_cmd;
  logic          push;
  logic          q_full;
  logic          q_not_empty;
  logic          pop;

  // Accept and classify
  wcs_front #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .DRAW_BITS   (DRAW_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  // Decouple front and back
  wcs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .not_empty (q_not_empty)
  );

  // Execute adds and searches
  wcs_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DRAW_BITS   (DRAW_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pop_cmd),
    .cmd_valid (q_not_empty),
    .cmd_pop   (pop),
    .results   (results)
  );

endmodule

// File: tb/tb_weighted_choice_sampler.sv
module tb_weighted_choice_sampler;

  localparam int TABLE_DEPTH  = wcs_pkg::MAX_ENTRIES_DEF;
  localparam int PHASE_WORDS  = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [wcs_pkg::TOTAL_BITS-1:0] TOTAL_CEIL = '1;

  // One input word as the sender offers it
  typedef struct {
    logic                            kind;
    logic [wcs_pkg::SITE_BITS-1:0]   site;
    logic [wcs_pkg::FIELD_BITS-1:0]  weight;
    logic [wcs_pkg::ALLELE_BITS-1:0] ref_allele;
    logic [wcs_pkg::ALLELE_BITS-1:0] alt_allele;
    logic [wcs_pkg::FIELD_BITS-1:0]  random_draw;
  } sample_word_t;

  // One result word
  typedef struct {
    logic                                  empty_res;
    logic signed [wcs_pkg::FIELD_BITS-1:0] chosen_site;
    logic [wcs_pkg::ALLELE_BITS-1:0]       chosen_ref;
    logic [wcs_pkg::ALLELE_BITS-1:0]       chosen_alt;
    logic [wcs_pkg::FIELD_BITS-1:0]        chosen_weight;
    logic [wcs_pkg::TOTAL_BITS-1:0]        total_weight;
  } choice_t;

  // Mirror of the weighted table; predicts each choice and checks it
  class weighted_table_model;
    sample_word_t                   entries[TABLE_DEPTH];
    logic [wcs_pkg::TOTAL_BITS-1:0] cumulative[TABLE_DEPTH];
    logic [wcs_pkg::TOTAL_BITS-1:0] running_total;
    int                             entry_count;
    choice_t                        expected_choices[$];
    int                             mismatches;

    function new();
      running_total = '0;
      entry_count   = 0;
      mismatches    = 0;
    endfunction

    // Apply one accepted word: extend the table or queue the expected choice
    function void take_word(sample_word_t w);
      logic [wcs_pkg::TOTAL_BITS:0]                     sum;
      logic [wcs_pkg::FIELD_BITS+wcs_pkg::TOTAL_BITS-1:0] scaled;
      logic [wcs_pkg::TOTAL_BITS-1:0]                   threshold;
      int                                               lo;
      int                                               hi;
      int                                               mid;
      choice_t                                          c;
      if (w.kind == wcs_pkg::KIND_ADD) begin
        // drop adds once the table is full
        if (entry_count >= TABLE_DEPTH) return;
        sum = {1'b0, running_total} +
              {{(wcs_pkg::TOTAL_BITS+1-wcs_pkg::FIELD_BITS){1'b0}}, w.weight};
        running_total = sum[wcs_pkg::TOTAL_BITS] ? TOTAL_CEIL :
                        sum[wcs_pkg::TOTAL_BITS-1:0];
        cumulative[entry_count] = running_total;
        entries[entry_count]    = w;
        entry_count++;
        return;
      end
      c.total_weight = running_total;
      if (entry_count == 0) begin
        c.empty_res     = 1'b1;
        c.chosen_site   = -1;
        c.chosen_ref    = wcs_pkg::EMPTY_CODE;
        c.chosen_alt    = wcs_pkg::EMPTY_CODE;
        c.chosen_weight = '0;
      end else begin
        // scale the draw by the total, then find the first cumulative >= threshold
        scaled = {{wcs_pkg::TOTAL_BITS{1'b0}}, w.random_draw} *
                 {{wcs_pkg::FIELD_BITS{1'b0}}, running_total};
        threshold = scaled[wcs_pkg::FIELD_BITS+wcs_pkg::TOTAL_BITS-1:wcs_pkg::FIELD_BITS];
        lo = 0;
        hi = entry_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (cumulative[mid] < threshold) lo = mid + 1;
          else hi = mid;
        end
        if (lo >= entry_count) lo = entry_count - 1;
        c.empty_res     = 1'b0;
        c.chosen_site   = {1'b0, entries[lo].site};
        c.chosen_ref    = entries[lo].ref_allele;
        c.chosen_alt    = entries[lo].alt_allele;
        c.chosen_weight = entries[lo].weight;
      end
      expected_choices.insert(expected_choices.size(), c);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
    endtask

    // Compare one result word against the oldest expectation
    task check_choice(choice_t got);
      choice_t want;
      if (expected_choices.size() == 0) begin
        report_mismatch("unexpected result word", 64'(got.chosen_site), '0);
        return;
      end
      want = expected_choices.pop_front();
      if (got.empty_res !== want.empty_res)
        report_mismatch("empty_res", 64'(got.empty_res), 64'(want.empty_res));
      if (got.chosen_site !== want.chosen_site)
        report_mismatch("chosen_site", 64'(got.chosen_site), 64'(want.chosen_site));
      if (got.chosen_ref !== want.chosen_ref)
        report_mismatch("chosen_ref", 64'(got.chosen_ref), 64'(want.chosen_ref));
      if (got.chosen_alt !== want.chosen_alt)
        report_mismatch("chosen_alt", 64'(got.chosen_alt), 64'(want.chosen_alt));
      if (got.chosen_weight !== want.chosen_weight)
        report_mismatch("chosen_weight", 64'(got.chosen_weight), 64'(want.chosen_weight));
      if (got.total_weight !== want.total_weight)
        report_mismatch("total_weight", 64'(got.total_weight), 64'(want.total_weight));
    endtask
  endclass

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_go;
  int   stall_cycles = 0;

  weighted_table_model table_model;

  wcs_in_if  items_bus ();
  wcs_out_if results_bus ();

  weighted_choice_sampler DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_bus),
    .results (results_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one word, idling first at the current rate, and note it once accepted
  task automatic send_word(sample_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      items_bus.valid <= 1'b0;
      @(posedge clk);
    end
    items_bus.valid       <= 1'b1;
    items_bus.kind        <= w.kind;
    items_bus.site        <= w.site;
    items_bus.weight      <= w.weight;
    items_bus.ref_allele  <= w.ref_allele;
    items_bus.alt_allele  <= w.alt_allele;
    items_bus.random_draw <= w.random_draw;
    @(posedge clk);
    while (!items_bus.ready) @(posedge clk);
    table_model.take_word(w);
  endtask

  task automatic add_entry(logic [wcs_pkg::SITE_BITS-1:0] site,
                           logic [wcs_pkg::FIELD_BITS-1:0] weight,
                           logic [wcs_pkg::ALLELE_BITS-1:0] ref_code,
                           logic [wcs_pkg::ALLELE_BITS-1:0] alt_code);
    sample_word_t w;
    w = '{wcs_pkg::KIND_ADD, site, weight, ref_code, alt_code, '0};
    send_word(w);
  endtask

  task automatic choose(logic [wcs_pkg::FIELD_BITS-1:0] draw);
    sample_word_t w;
    w = '{wcs_pkg::KIND_CHOOSE, '0, '0, '0, '0, draw};
    send_word(w);
  endtask

  // Random word; weights lean toward zero, tiny and full-scale values, draws toward zero and full scale
  function automatic sample_word_t random_word(int choose_pct);
    sample_word_t w;
    logic [31:0]  rnd;
    w.kind       = ($urandom_range(99) < choose_pct) ? wcs_pkg::KIND_CHOOSE
                                                      : wcs_pkg::KIND_ADD;
    rnd          = $urandom;
    w.site       = rnd[wcs_pkg::SITE_BITS-1:0];
    rnd          = $urandom;
    w.ref_allele = rnd[wcs_pkg::ALLELE_BITS-1:0];
    rnd          = $urandom;
    w.alt_allele = rnd[wcs_pkg::ALLELE_BITS-1:0];
    case ($urandom_range(7))
      0:       w.weight = '0;
      1:       w.weight = '1;
      2:       w.weight = $urandom_range(15);
      default: w.weight = $urandom;
    endcase
    case ($urandom_range(9))
      0:       w.random_draw = '0;
      1:       w.random_draw = '1;
      default: w.random_draw = $urandom;
    endcase
    return w;
  endfunction

  // Drop valid and hold the sender until every expected result has come back
  task automatic wait_drained();
    items_bus.valid <= 1'b0;
    while (table_model.expected_choices.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int words);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (words) send_word(random_word(50));
  endtask

  // Receiver: check accepted results, then pick next ready (long hold when asked)
  initial begin
    int  hold_left;
    bit  hold_taken;
    choice_t got;
    hold_left  = 0;
    hold_taken = 1'b0;
    results_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_bus.valid && results_bus.ready) begin
        got.empty_res     = results_bus.empty_res;
        got.chosen_site   = results_bus.chosen_site;
        got.chosen_ref    = results_bus.chosen_ref;
        got.chosen_alt    = results_bus.chosen_alt;
        got.chosen_weight = results_bus.chosen_weight;
        got.total_weight  = results_bus.total_weight;
        table_model.check_choice(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        results_bus.ready <= 1'b0;
      end else if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        results_bus.ready <= 1'b0;
      end else begin
        results_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((items_bus.valid && items_bus.ready) || (results_bus.valid && results_bus.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("weighted_choice_sampler regression: fail");
      $finish;
    end
  end

  initial begin
    table_model  = new();
    hold_go      = 1'b0;
    tx_idle_pct  = 9;
    rx_idle_pct  = 65;
    rst = 1'b1;
    items_bus.valid       = 1'b0;
    items_bus.kind        = wcs_pkg::KIND_ADD;
    items_bus.site        = '0;
    items_bus.weight      = '0;
    items_bus.ref_allele  = '0;
    items_bus.alt_allele  = '0;
    items_bus.random_draw = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table returns the empty marker
    choose('0);
    choose('1);
    // a lone zero weight: threshold is zero, entry 0 wins
    add_entry('0, '0, '0, '0);
    choose('0);
    choose('1);
    // extremes and alternating patterns, a zero weight in the middle
    add_entry('1, '1, 8'hFF, 8'hFF);
    add_entry(31'h2AAAAAAA, 32'h55555555, 8'hAA, 8'h55);
    add_entry(31'h55555555, 32'hAAAAAAAA, 8'h55, 8'hAA);
    add_entry(31'd12345, '0, "A", "G");
    add_entry(31'd7, 32'd1, "C", "T");
    choose('0);
    choose(32'd1);
    choose(32'h80000000);
    choose(32'h3FFFFFFF);
    choose(32'hFFFFFFFE);
    choose('1);
    wait_drained();

    // long receiver hold while the sender keeps offering words
    hold_go = 1'b1;
    run_phase(9, 65, PHASE_WORDS);
    wait_drained();
    run_phase(65, 9, PHASE_WORDS);
    wait_drained();
    run_phase(0, 0, PHASE_WORDS);
    choose('0);
    choose('1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_model.mismatches == 0)
      $display("weighted_choice_sampler regression: pass");
    else
      $display("weighted_choice_sampler regression: fail");
    $finish;
  end

endmodule
